>>> src/mrrp_pkg.sv
// ----------------------------------------------------------------------------
// Memory reply record parser package
// Shared types and constants for the memory-channel reply parser.
// ----------------------------------------------------------------------------
package mrrp_pkg;

  // Number of significant characters in a memory-channel reply.
  localparam logic [4:0] REC_LEN = 5'd28;

  // Characters that the parser checks for.
  localparam logic [7:0] CH_M     = 8'h4D;  // 'M'
  localparam logic [7:0] CH_R     = 8'h52;  // 'R'
  localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_1     = 8'h31;  // '1'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'
  localparam logic [7:0] CH_A     = 8'h41;  // 'A'
  localparam logic [7:0] CH_F     = 8'h46;  // 'F'
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Record status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_MALFORMED = 2'd2
  } status_e;

  // Parser state carried from one character to the next.
  typedef struct packed {
    logic [4:0]  position;
    logic        bad_flag;
    logic [15:0] first_chars;
    logic [23:0] channel_acc;
    logic [29:0] freq_acc;
    logic [13:0] clar_acc;
    logic        clar_negative;
    logic [1:0]  clar_flags;    // bit 0 rx, bit 1 tx
    logic [3:0]  mode_reg;
    logic [18:0] digit_fields;  // state 18:15, tone mode 14:11, tone 10:4, shift 3:0
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '0;

  // One decoded record.
  typedef struct packed {
    status_e            status;
    logic [6:0]         slot;
    logic [23:0]        channel_text;
    logic [29:0]        freq_hz;
    logic signed [14:0] clarifier_hz;
    logic               rx_clar_on;
    logic               tx_clar_on;
    logic [3:0]         op_mode;
    logic [3:0]         radio_state;
    logic [3:0]         tone_mode;
    logic [6:0]         tone_number;
    logic [3:0]         shift_digit;
  } record_t;

endpackage

>>> src/mrrp_byte_step.sv
// ----------------------------------------------------------------------------
// Memory reply record parser: character step
// Folds one reply character into the parser state by its position.
// ----------------------------------------------------------------------------
module mrrp_byte_step (
  input  mrrp_pkg::parse_state_t cur_i,
  input  logic [7:0]             data_byte_i,
  output mrrp_pkg::parse_state_t nxt_o
);
  import mrrp_pkg::*;

  logic       is_dig;
  logic [3:0] digit;
  logic [6:0] tone_cur;

  assign is_dig   = (data_byte_i >= CH_0) && (data_byte_i <= CH_9);
  assign digit    = data_byte_i[3:0];
  assign tone_cur = cur_i.digit_fields[10:4];

  always_comb begin
    nxt_o = cur_i;
    if (cur_i.position < REC_LEN) begin
      if (data_byte_i == CH_NUL) begin
        nxt_o.bad_flag = 1'b1;
      end
      case (cur_i.position) inside
        // Prefix characters.
        [5'd0:5'd1]: begin
          nxt_o.first_chars = {cur_i.first_chars[7:0], data_byte_i};
          if (data_byte_i != ((cur_i.position == 5'd0) ? CH_M : CH_R)) begin
            nxt_o.bad_flag = 1'b1;
          end
        end
        // Raw channel text.
        [5'd2:5'd4]: begin
          nxt_o.channel_acc = {cur_i.channel_acc[15:0], data_byte_i};
        end
        // Frequency digits.
        [5'd5:5'd13]: begin
          if (is_dig) begin
            nxt_o.freq_acc = 30'({cur_i.freq_acc, 3'b000}) + 30'({cur_i.freq_acc, 1'b0})
                           + 30'(digit);
          end else begin
            nxt_o.bad_flag = 1'b1;
          end
        end
        5'd14: begin
          if (data_byte_i == CH_MINUS) begin
            nxt_o.clar_negative = 1'b1;
          end else if (data_byte_i != CH_PLUS) begin
            nxt_o.bad_flag = 1'b1;
          end
        end
        // Clarifier digits.
        [5'd15:5'd18]: begin
          if (is_dig) begin
            nxt_o.clar_acc = 14'({cur_i.clar_acc, 3'b000}) + 14'({cur_i.clar_acc, 1'b0})
                           + 14'(digit);
          end else begin
            nxt_o.bad_flag = 1'b1;
          end
        end
        5'd19: begin
          if (data_byte_i == CH_1) begin
            nxt_o.clar_flags[0] = 1'b1;
          end
        end
        5'd20: begin
          if (data_byte_i == CH_1) begin
            nxt_o.clar_flags[1] = 1'b1;
          end
        end
        5'd21: begin
          if ((data_byte_i >= CH_1) && (data_byte_i <= CH_9)) begin
            nxt_o.mode_reg = digit;
          end else if ((data_byte_i >= CH_A) && (data_byte_i <= CH_F)) begin
            nxt_o.mode_reg = digit + 4'd9;  // 'A' has low nibble 1
          end else begin
            nxt_o.bad_flag = 1'b1;
          end
        end
        [5'd22:5'd26]: begin
          if (!is_dig) begin
            nxt_o.bad_flag = 1'b1;
          end else if (cur_i.position == 5'd22) begin
            nxt_o.digit_fields[18:15] = cur_i.digit_fields[18:15] | digit;
          end else if (cur_i.position == 5'd23) begin
            nxt_o.digit_fields[14:11] = cur_i.digit_fields[14:11] | digit;
          end else if (cur_i.position == 5'd26) begin
            nxt_o.digit_fields[3:0] = cur_i.digit_fields[3:0] | digit;
          end else begin
            nxt_o.digit_fields[10:4] = 7'({tone_cur, 3'b000}) + 7'({tone_cur, 1'b0})
                                     + 7'(digit);
          end
        end
        default: begin
        end
      endcase
      nxt_o.position = cur_i.position + 5'd1;
    end
  end

endmodule

>>> src/memory_reply_record_parser_core.sv
// ----------------------------------------------------------------------------
// Memory reply record parser core
// Parses a radio memory-channel reply, one character per transaction, into
// one decoded record per reply.
// ----------------------------------------------------------------------------
// Timing: an accepted character is held in the input register and is then
//   folded into the parser state; a final character resets the state and
//   loads the output record register, which drives the record output.
// Throughput: one character per cycle, except while a final character waits on the output.
// Reset: rst_ni clears the input and output valid flags and the parser state;
//   the block takes characters right after reset is released.
module memory_reply_record_parser_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input characters.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [7:0] data_byte, [14:8] slot_number, [15] zero
  input  logic         s_axis_tlast,   // last character of the reply
  // Output records.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [8:2] slot, [32:9] channel_text, [62:33] freq_hz,
  // [77:63] clarifier_hz, [78] rx_clar_on, [79] tx_clar_on,
  // [83:80] op_mode, [87:84] radio_state, [91:88] tone_mode,
  // [98:92] tone_number, [102:99] shift_digit, [103] zero
  output logic [103:0] m_axis_tdata
);
  import mrrp_pkg::*;

  // Input register stage. It holds one character until the parser takes it.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic [6:0] in_slot_q;

  // Parser state and the output record register.
  parse_state_t st_q, st_step;
  logic         out_vld_q;
  record_t      out_rec_q, rec_d;

  logic consume;
  logic in_acc;

  // The parser takes the held character unless it closes a reply while the
  // previous record is still waiting to be taken downstream.
  assign consume       = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || consume;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  mrrp_byte_step u_step (
    .cur_i       (st_q),
    .data_byte_i (in_byte_q),
    .nxt_o       (st_step)
  );

  // Record for a reply that ends with the held character. Status is taken
  // from the state after that character has been folded in.
  always_comb begin
    rec_d      = '0;
    rec_d.slot = in_slot_q;
    if ((st_step.position == 5'd2) && (st_step.first_chars == {CH_QUERY, CH_SEMI})) begin
      rec_d.status = STATUS_EMPTY;
    end else if ((st_step.position >= REC_LEN) && !st_step.bad_flag
                 && (st_step.freq_acc != 30'd0)) begin
      rec_d.status = STATUS_OK;
    end else begin
      rec_d.status = STATUS_MALFORMED;
    end
    // Every field but status and slot is zero unless the reply is good.
    if (rec_d.status == STATUS_OK) begin
      rec_d.channel_text = st_step.channel_acc;
      rec_d.freq_hz      = st_step.freq_acc;
      rec_d.clarifier_hz = st_step.clar_negative ? (15'sd0 - $signed({1'b0, st_step.clar_acc}))
                                                 : $signed({1'b0, st_step.clar_acc});
      rec_d.rx_clar_on   = st_step.clar_flags[0];
      rec_d.tx_clar_on   = st_step.clar_flags[1];
      rec_d.op_mode      = st_step.mode_reg;
      rec_d.radio_state  = st_step.digit_fields[18:15];
      rec_d.tone_mode    = st_step.digit_fields[14:11];
      rec_d.tone_number  = st_step.digit_fields[10:4];
      rec_d.shift_digit  = st_step.digit_fields[3:0];
    end
  end

  // Control state: valid flags and the parser state, which returns to its
  // reset value after each final character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= STATE_RESET;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (consume) begin
        in_vld_q <= 1'b0;
      end
      if (consume) begin
        st_q <= in_last_q ? STATE_RESET : st_step;
      end
      if (consume && in_last_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_slot_q <= s_axis_tdata[14:8];
      in_last_q <= s_axis_tlast;
    end
    if (consume && in_last_q) begin
      out_rec_q <= rec_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0,
                          out_rec_q.shift_digit,
                          out_rec_q.tone_number,
                          out_rec_q.tone_mode,
                          out_rec_q.radio_state,
                          out_rec_q.op_mode,
                          out_rec_q.tx_clar_on,
                          out_rec_q.rx_clar_on,
                          out_rec_q.clarifier_hz,
                          out_rec_q.freq_hz,
                          out_rec_q.channel_text,
                          out_rec_q.slot,
                          out_rec_q.status};

endmodule

>>> src/mrrp_checker.sv
// ----------------------------------------------------------------------------
// Memory reply record parser checker
// Port-level checks on the records leaving the parser core.
// ----------------------------------------------------------------------------
module mrrp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);
  import mrrp_pkg::*;

  // A stalled record transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("record changed while stalled");

  // With no record waiting, the input side always takes a character.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no record waiting");

  // Status is one of the three defined codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == STATUS_OK) || (m_axis_tdata[1:0] == STATUS_EMPTY)
                      || (m_axis_tdata[1:0] == STATUS_MALFORMED))
    else $error("undefined record status");

  // Empty and malformed records carry only status and slot.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != STATUS_OK) |-> (m_axis_tdata[103:9] == '0))
    else $error("non-ok record carries field data");

  // A good record always has a nonzero frequency.
  a_ok_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == STATUS_OK) |-> (m_axis_tdata[62:33] != 30'd0))
    else $error("ok record with zero frequency");

endmodule

bind memory_reply_record_parser_core mrrp_checker u_mrrp_checker (.*);
